// File: rtl/cbdp_pkg.sv
// Shared types and constants for the codebook int8 dot product block.
// Used by the channel interfaces and the top level; depends on nothing.
package cbdp_pkg;

  localparam int CODEBOOK_DEPTH = 256;
  localparam int MAX_ELEMENTS   = 1024;
  localparam int MAX_WORDS      = 256;

  localparam int ADDR_W    = 8;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 8;
  localparam int BITS_W    = 4;
  localparam int ELEM_W    = 11;
  localparam int WPTR_W    = 9;
  localparam int SLOT_W    = 6;
  localparam int SHIFT_W   = 5;
  localparam int IDX_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_INDEX  = 2'd1,
    MODE_ACT    = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_INDEX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_ENABLE   = 3'd5;

  // Indices that fit in one 32-bit word, per index width.
  localparam logic [SLOT_W-1:0] PER_WORD [16] = '{
    6'd0,  6'd32, 6'd16, 6'd10, 6'd8, 6'd6, 6'd5, 6'd4,
    6'd4,  6'd3,  6'd3,  6'd2,  6'd2, 6'd2, 6'd2, 6'd2
  };

endpackage

// File: rtl/cbdp_item_if.sv
// Request channel into the codebook dot product block: valid/ready plus payload.
// Depends on cbdp_pkg for field widths.
interface cbdp_item_if import cbdp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [ADDR_W-1:0]        table_address;
  logic signed [WORD_W-1:0] codebook_weight;
  logic [WORD_W-1:0]        index_word;
  logic signed [ACT_W-1:0]  activation;
  logic signed [WORD_W-1:0] prior_output;

  modport source (
    output valid, mode, table_address, codebook_weight, index_word, activation,
           prior_output,
    input  ready
  );
  modport sink (
    input  valid, mode, table_address, codebook_weight, index_word, activation,
           prior_output,
    output ready
  );
endinterface

// File: rtl/cbdp_result_if.sv
// Result channel out of the codebook dot product block: valid/ready plus row result.
// Depends on cbdp_pkg for field widths.
interface cbdp_result_if import cbdp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] row_result;

  modport source (output valid, row_result, input ready);
  modport sink   (input valid, row_result, output ready);
endinterface

// File: rtl/codebook_int8_dot_product_top.sv
// Codebook int8 dot product: four-stage pipeline around the index word and weight memories.
// Depends on cbdp_pkg, cbdp_item_if and cbdp_result_if.
//
// Usage: load the codebook (mode 0) and the packed index words (mode 1), then stream
// activations (mode 2) and close the row with a finish request (mode 3), which yields
// one row_result. Only finish requests produce a result.
// Configuration is written through cfg_write / cfg_index / cfg_data while idle.
// Throughput: one request per cycle of any mode while item.ready is high. Each request
// reads the index word memory on acceptance and the weight memory in the cycle after;
// the multiply and the accumulate each take one more stage.
// A finish request passes through the s1_fin, s2_fin and s3_fin registers, then its
// result is written to the output queue and shows on the result channel.
// Stalls: results wait in a 4-entry output queue. The item channel drops ready only
// when four finish requests are accepted but not yet taken by the receiver; other
// requests keep flowing as long as that holds.
// Reset: clears the row state, the pipeline, the output queue and the configuration
// (bits_per_index 4, all else 0). The two memories are not cleared; load them first.
module codebook_int8_dot_product_top import cbdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  cbdp_item_if.sink            item,
  cbdp_result_if.source        result
);

  // configuration
  logic [BITS_W-1:0]        bits_per_index;
  logic [ELEM_W-1:0]        element_count;
  logic [WPTR_W-1:0]        words_per_row;
  logic [WORD_W-1:0]        bias_value;
  logic                     bias_enable;
  logic                     accumulate_enable;

  // memories
  logic [WORD_W-1:0]        index_mem  [MAX_WORDS];
  logic [WORD_W-1:0]        weight_mem [CODEBOOK_DEPTH];
  logic [WORD_W-1:0]        word_rdata;
  logic signed [WORD_W-1:0] weight_rdata;

  // row state
  logic [ELEM_W-1:0]        element_position;
  logic [WPTR_W-1:0]        word_pointer;
  logic [SLOT_W-1:0]        slot_in_word;
  logic [WORD_W-1:0]        running_sum;
  logic [ELEM_W-1:0]        element_position_next;
  logic [WPTR_W-1:0]        word_pointer_next;
  logic [SLOT_W-1:0]        slot_in_word_next;

  // stage 0 decode
  logic                     accept;
  logic                     fin_accept;
  logic [SLOT_W-1:0]        per_word;
  logic                     wrap_first;
  logic [SLOT_W-1:0]        slot_a;
  logic [WPTR_W-1:0]        wp_a;
  logic [SLOT_W-1:0]        slot_b;
  logic [ELEM_W-1:0]        limit_e;
  logic [WPTR_W-1:0]        limit_w;
  logic                     live;
  logic [9:0]               shift_full;
  logic [WORD_W-1:0]        extra;

  // pipeline registers
  logic                     s1_act, s1_fin;
  logic signed [ACT_W-1:0]  s1_act_val;
  logic [SHIFT_W-1:0]       s1_shift;
  logic [BITS_W-1:0]        s1_bits;
  logic [WORD_W-1:0]        s1_extra;
  logic [IDX_W-1:0]         s1_idx;
  logic                     s2_act, s2_fin, s2_oob;
  logic signed [ACT_W-1:0]  s2_act_val;
  logic [WORD_W-1:0]        s2_extra;
  logic signed [WORD_W-1:0] s2_weight;
  logic                     s3_act, s3_fin;
  logic [WORD_W-1:0]        s3_prod;
  logic [WORD_W-1:0]        s3_extra;

  // output queue
  logic [WORD_W-1:0]        out_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     out_wr_ptr, out_rd_ptr;
  logic [OUT_CNT_W-1:0]     out_count;
  logic [OUT_CNT_W-1:0]     pending;
  logic                     out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_index    <= BITS_W'(4);
      element_count     <= '0;
      words_per_row     <= '0;
      bias_value        <= '0;
      bias_enable       <= 1'b0;
      accumulate_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BITS_PER_INDEX: bits_per_index    <= cfg_data[BITS_W-1:0];
        CFG_ELEMENT_COUNT:  element_count     <= cfg_data[ELEM_W-1:0];
        CFG_WORDS_PER_ROW:  words_per_row     <= cfg_data[WPTR_W-1:0];
        CFG_BIAS_VALUE:     bias_value        <= cfg_data;
        CFG_BIAS_ENABLE:    bias_enable       <= cfg_data[0];
        CFG_ACCUM_ENABLE:   accumulate_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item.ready = (pending < OUT_CNT_W'(OUT_DEPTH));
  assign accept     = item.valid && item.ready;
  assign fin_accept = accept && (item.mode == MODE_FINISH);

  always_comb begin
    per_word   = PER_WORD[bits_per_index];
    wrap_first = (bits_per_index != '0) && (slot_in_word >= per_word);
    slot_a     = wrap_first ? '0 : slot_in_word;
    wp_a       = wrap_first ? word_pointer + WPTR_W'(1) : word_pointer;
    limit_e    = (element_count > ELEM_W'(MAX_ELEMENTS)) ? ELEM_W'(MAX_ELEMENTS)
                                                         : element_count;
    limit_w    = (words_per_row > WPTR_W'(MAX_WORDS)) ? WPTR_W'(MAX_WORDS) : words_per_row;
    live       = (bits_per_index != '0) && (element_position < limit_e) && (wp_a < limit_w);
    slot_b     = slot_a + SLOT_W'(1);
    shift_full = slot_a * bits_per_index;
    extra      = (bias_enable ? bias_value : '0)
               + (accumulate_enable ? WORD_W'(item.prior_output) : '0);

    element_position_next = element_position;
    word_pointer_next     = word_pointer;
    slot_in_word_next     = slot_in_word;
    if (item.mode == MODE_FINISH) begin
      element_position_next = '0;
      word_pointer_next     = '0;
      slot_in_word_next     = '0;
    end else if (item.mode == MODE_ACT && bits_per_index != '0) begin
      word_pointer_next = wp_a;
      slot_in_word_next = slot_a;
      if (live) begin
        element_position_next = element_position + ELEM_W'(1);
        // advance to the next word once this one is used up
        if (slot_b >= per_word) begin
          slot_in_word_next = '0;
          word_pointer_next = wp_a + WPTR_W'(1);
        end else begin
          slot_in_word_next = slot_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_position <= '0;
      word_pointer     <= '0;
      slot_in_word     <= '0;
    end else if (accept) begin
      element_position <= element_position_next;
      word_pointer     <= word_pointer_next;
      slot_in_word     <= slot_in_word_next;
    end
  end

  // Table writes land at acceptance; a read issued at the same edge sees the old word.
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_INDEX) begin
      index_mem[item.table_address] <= item.index_word;
    end
    word_rdata <= index_mem[wp_a[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_WEIGHT) begin
      weight_mem[item.table_address] <= item.codebook_weight;
    end
    weight_rdata <= weight_mem[s1_idx[ADDR_W-1:0]];
  end

  // stage 1: extract the index from the word just read
  always_comb begin
    s1_idx = IDX_W'(word_rdata >> s1_shift)
           & ((IDX_W'(1) << s1_bits) - IDX_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_act <= 1'b0;
      s1_fin <= 1'b0;
      s2_act <= 1'b0;
      s2_fin <= 1'b0;
      s3_act <= 1'b0;
      s3_fin <= 1'b0;
    end else begin
      s1_act <= accept && item.mode == MODE_ACT && live;
      s1_fin <= fin_accept;
      s2_act <= s1_act;
      s2_fin <= s1_fin;
      s3_act <= s2_act;
      s3_fin <= s2_fin;
    end
  end

  always_ff @(posedge clk) begin
    s1_act_val <= item.activation;
    s1_shift   <= shift_full[SHIFT_W-1:0];
    s1_bits    <= bits_per_index;
    s1_extra   <= extra;
    s2_act_val <= s1_act_val;
    s2_oob     <= |s1_idx[IDX_W-1:ADDR_W];
    s2_extra   <= s1_extra;
    s3_prod    <= 32'(s2_act_val * s2_weight);
    s3_extra   <= s2_extra;
  end

  // indices past the codebook weigh zero
  assign s2_weight = s2_oob ? '0 : weight_rdata;

  // stage 3: accumulate, or emit and clear on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (s3_fin) begin
      running_sum <= '0;
    end else if (s3_act) begin
      running_sum <= running_sum + s3_prod;
    end
  end

  assign out_pop           = result.valid && result.ready;
  assign result.valid      = (out_count != '0);
  assign result.row_result = out_mem[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (s3_fin) begin
      out_mem[out_wr_ptr] <= running_sum + s3_extra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
      pending    <= '0;
    end else begin
      if (s3_fin) begin
        out_wr_ptr <= out_wr_ptr + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + OUT_PTR_W'(1);
      end
      out_count <= out_count + OUT_CNT_W'(s3_fin) - OUT_CNT_W'(out_pop);
      // count finish requests accepted but not yet delivered
      pending   <= pending + OUT_CNT_W'(fin_accept) - OUT_CNT_W'(out_pop);
    end
  end

endmodule

// File: verif/codebook_int8_dot_product_top_tb.sv
// Self-checking testbench for codebook_int8_dot_product_top: directed and random
// request traffic under several handshake pacing phases, checked against a row predictor.
// Depends on cbdp_pkg, cbdp_item_if and cbdp_result_if.
module codebook_int8_dot_product_top_tb;
  import cbdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_SETTLE    = 6;
  localparam int PHASE_BUDGET   = 195;

  typedef struct {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] word;
    logic [ACT_W-1:0]  act;
    logic [WORD_W-1:0] prior;
  } cbdp_req_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  cbdp_item_if   item_ch ();
  cbdp_result_if result_ch ();

  codebook_int8_dot_product_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Predictor state: tables, row progress and the register copies.
  logic [WORD_W-1:0] weight_mem [CODEBOOK_DEPTH];
  bit                weight_set [CODEBOOK_DEPTH];
  logic [WORD_W-1:0] word_mem [MAX_WORDS];
  bit                word_set [MAX_WORDS];
  logic [WORD_W-1:0] dot_sum;
  int unsigned       elem_pos;
  int unsigned       word_ptr;
  int unsigned       slot_pos;

  logic [BITS_W-1:0] bits_cfg;
  logic [ELEM_W-1:0] elems_cfg;
  logic [WPTR_W-1:0] words_cfg;
  logic [WORD_W-1:0] bias_cfg;
  logic              bias_en_cfg;
  logic              accum_en_cfg;

  logic [WORD_W-1:0] expected_rows [$];

  int error_count   = 0;
  int requests_sent = 0;
  int rows_checked  = 0;
  int reg_writes    = 0;
  int idle_cycles   = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    result_ch.ready = (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : row_checker
    logic [WORD_W-1:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_rows.size() == 0) begin
        flag_error($sformatf("row_result %h with no finish request pending",
                             result_ch.row_result));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (result_ch.row_result !== want)
          flag_error($sformatf("row_result %h, expected %h", result_ch.row_result, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        flag_error("no handshake progress, run stopped");
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Where the next activation would read: index word address and extracted index.
  function automatic bit lookup_slot(output int waddr, output int widx);
    int unsigned lim_e;
    int unsigned lim_w;
    int unsigned per_word;
    int unsigned slot_now;
    int unsigned ptr_now;
    waddr = 0;
    widx  = 0;
    if (bits_cfg == 0) return 1'b0;
    lim_e    = (elems_cfg > MAX_ELEMENTS) ? MAX_ELEMENTS : elems_cfg;
    lim_w    = (words_cfg > MAX_WORDS) ? MAX_WORDS : words_cfg;
    per_word = 32 / bits_cfg;
    slot_now = slot_pos;
    ptr_now  = word_ptr;
    if (slot_now >= per_word) begin
      slot_now = 0;
      ptr_now++;
    end
    if (elem_pos >= lim_e || ptr_now >= lim_w) return 1'b0;
    waddr = ptr_now;
    widx  = (word_mem[ptr_now] >> (slot_now * bits_cfg)) & ((32'd1 << bits_cfg) - 1);
    return 1'b1;
  endfunction

  task automatic accumulate_activation(input logic [ACT_W-1:0] act);
    int          waddr;
    int          widx;
    int unsigned per_word;
    bit          hit;
    logic [WORD_W-1:0] wt;
    logic [WORD_W-1:0] ax;
    if (bits_cfg == 0) return;
    hit      = lookup_slot(waddr, widx);
    per_word = 32 / bits_cfg;
    // width shrank under a partly used word: move on to the next word
    if (slot_pos >= per_word) begin
      slot_pos = 0;
      word_ptr++;
    end
    if (!hit) return;
    wt      = (widx < CODEBOOK_DEPTH) ? weight_mem[widx] : '0;
    ax      = {{(WORD_W-ACT_W){act[ACT_W-1]}}, act};
    dot_sum = dot_sum + ax * wt;
    elem_pos++;
    slot_pos++;
    if (slot_pos >= per_word) begin
      slot_pos = 0;
      word_ptr++;
    end
  endtask

  task automatic predict_request(input cbdp_req_t req);
    logic [WORD_W-1:0] row_value;
    case (req.mode)
      MODE_WEIGHT: begin
        weight_mem[req.addr] = req.weight;
        weight_set[req.addr] = 1'b1;
      end
      MODE_INDEX: begin
        word_mem[req.addr] = req.word;
        word_set[req.addr] = 1'b1;
      end
      MODE_ACT: accumulate_activation(req.act);
      MODE_FINISH: begin
        row_value = dot_sum;
        if (bias_en_cfg) row_value = row_value + bias_cfg;
        if (accum_en_cfg) row_value = row_value + req.prior;
        expected_rows.push_back(row_value);
        dot_sum  = '0;
        elem_pos = 0;
        word_ptr = 0;
        slot_pos = 0;
      end
    endcase
  endtask

  function automatic cbdp_req_t random_req(input mode_t m);
    cbdp_req_t r;
    r.mode   = m;
    r.addr   = ADDR_W'($urandom_range(255));
    r.weight = $urandom;
    r.word   = $urandom;
    r.act    = ACT_W'($urandom_range(255));
    r.prior  = $urandom;
    return r;
  endfunction

  task automatic send_request(input cbdp_req_t req);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
    end
    @(negedge clk);
    item_ch.valid           = 1'b1;
    item_ch.mode            = req.mode;
    item_ch.table_address   = req.addr;
    item_ch.codebook_weight = req.weight;
    item_ch.index_word      = req.word;
    item_ch.activation      = req.act;
    item_ch.prior_output    = req.prior;
    do @(posedge clk); while (!item_ch.ready);
    predict_request(req);
    requests_sent++;
  endtask

  // Load the index word and codebook entry the activation would read, if not yet written, before sending it.
  task automatic send_activation(input logic [ACT_W-1:0] act);
    int        waddr;
    int        widx;
    cbdp_req_t req;
    if (lookup_slot(waddr, widx)) begin
      if (!word_set[waddr]) begin
        req      = random_req(MODE_INDEX);
        req.addr = ADDR_W'(waddr);
        send_request(req);
      end
      void'(lookup_slot(waddr, widx));
      if (widx < CODEBOOK_DEPTH && !weight_set[widx]) begin
        req      = random_req(MODE_WEIGHT);
        req.addr = ADDR_W'(widx);
        send_request(req);
      end
    end
    req     = random_req(MODE_ACT);
    req.act = act;
    send_request(req);
  endtask

  task automatic send_finish(input logic [WORD_W-1:0] prior);
    cbdp_req_t req;
    req       = random_req(MODE_FINISH);
    req.prior = prior;
    send_request(req);
  endtask

  task automatic send_write(input mode_t m, input int addr, input logic [WORD_W-1:0] data);
    cbdp_req_t req;
    req        = random_req(m);
    req.addr   = ADDR_W'(addr);
    req.weight = data;
    req.word   = data;
    send_request(req);
  endtask

  // Hold off until every row result is out and the pipeline has emptied.
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    reg_writes++;
    case (idx)
      CFG_BITS_PER_INDEX: bits_cfg     = data[BITS_W-1:0];
      CFG_ELEMENT_COUNT:  elems_cfg    = data[ELEM_W-1:0];
      CFG_WORDS_PER_ROW:  words_cfg    = data[WPTR_W-1:0];
      CFG_BIAS_VALUE:     bias_cfg     = data;
      CFG_BIAS_ENABLE:    bias_en_cfg  = data[0];
      CFG_ACCUM_ENABLE:   accum_en_cfg = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int bits, input int elems, input int words,
                           input logic [WORD_W-1:0] bias, input bit bias_en, input bit acc_en);
    drain();
    write_reg(CFG_BITS_PER_INDEX, bits);
    write_reg(CFG_ELEMENT_COUNT, elems);
    write_reg(CFG_WORDS_PER_ROW, words);
    write_reg(CFG_BIAS_VALUE, bias);
    write_reg(CFG_BIAS_ENABLE, WORD_W'(bias_en));
    write_reg(CFG_ACCUM_ENABLE, WORD_W'(acc_en));
  endtask

  // Reset values: empty row, so activations drop and finish gives zero.
  task automatic test_reset_state();
    send_activation(ACT_W'($urandom_range(255)));
    send_finish($urandom);
  endtask

  task automatic test_field_extremes();
    configure(8, 4, 1, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_write(MODE_WEIGHT, 0, 32'h8000_0000);
    send_write(MODE_WEIGHT, 255, 32'h7FFF_FFFF);
    send_write(MODE_WEIGHT, 128, 32'hFFFF_FFFF);
    send_write(MODE_INDEX, 255, 32'hFFFF_FFFF);
    // bytes low first: 0xFF, 0x00, 0xFF, 0x80
    send_write(MODE_INDEX, 0, 32'h80FF_00FF);
    send_activation(8'h80);
    send_activation(8'h7F);
    send_activation(8'h80);
    send_activation(8'h7F);
    send_activation(8'h80);
    send_finish(32'h8000_0000);
  endtask

  task automatic test_width_change();
    configure(4, 16, 4, $urandom, 1'b1, 1'b0);
    repeat (3) send_activation(ACT_W'($urandom_range(255)));
    drain();
    // slot 3 is past the two indices a 15-bit word holds
    write_reg(CFG_BITS_PER_INDEX, 15);
    repeat (2) send_activation(ACT_W'($urandom_range(255)));
    drain();
    write_reg(CFG_BITS_PER_INDEX, 0);
    send_activation(ACT_W'($urandom_range(255)));
    send_finish($urandom);
  endtask

  task automatic test_word_limit();
    configure(15, 5, 1, 32'h8000_0000, 1'b1, 1'b1);
    repeat (4) send_activation(ACT_W'($urandom_range(255)));
    send_finish($urandom);
  endtask

  task automatic random_config();
    int bits;
    int elems;
    int words;
    int per_word;
    logic [WORD_W-1:0] bias;
    case ($urandom_range(9))
      0:       bits = 0;
      1, 2:    bits = $urandom_range(9, 15);
      default: bits = $urandom_range(1, 8);
    endcase
    case ($urandom_range(9))
      0:       elems = 0;
      1:       elems = MAX_ELEMENTS;
      2:       elems = 2047;
      default: elems = $urandom_range(1, 40);
    endcase
    per_word = (bits == 0) ? 32 : 32 / bits;
    case ($urandom_range(9))
      0:       words = 0;
      1:       words = 511;
      2:       words = MAX_WORDS;
      3:       words = $urandom_range(0, 511);
      default: words = (elems + per_word - 1) / per_word + $urandom_range(0, 1);
    endcase
    if (words > 511) words = 511;
    case ($urandom_range(5))
      0:       bias = 32'h8000_0000;
      1:       bias = 32'h7FFF_FFFF;
      default: bias = $urandom;
    endcase
    configure(bits, elems, words, bias, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Random-length rows; some overrun the count, some carry table writes mid-row.
  task automatic send_random_row();
    int row_cap;
    int row_len;
    int pick;
    row_cap = (elems_cfg > 40) ? 40 : elems_cfg;
    row_len = $urandom_range(0, row_cap + 3);
    repeat (row_len) begin
      pick = $urandom_range(99);
      if (pick < 5)
        send_write(MODE_WEIGHT, $urandom_range(255), $urandom);
      else if (pick < 9)
        send_write(MODE_INDEX, $urandom_range(255), $urandom);
      else
        send_activation(ACT_W'($urandom_range(255)));
    end
    send_finish($urandom);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int start_count;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start_count  = requests_sent;
    while (requests_sent - start_count < PHASE_BUDGET) begin
      random_config();
      repeat ($urandom_range(2, 5)) send_random_row();
    end
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    item_ch.valid           = 1'b0;
    item_ch.mode            = MODE_WEIGHT;
    item_ch.table_address   = '0;
    item_ch.codebook_weight = '0;
    item_ch.index_word      = '0;
    item_ch.activation      = '0;
    item_ch.prior_output    = '0;
    for (int i = 0; i < CODEBOOK_DEPTH; i++) begin
      weight_mem[i] = '0;
      weight_set[i] = 1'b0;
    end
    for (int i = 0; i < MAX_WORDS; i++) begin
      word_mem[i] = '0;
      word_set[i] = 1'b0;
    end
    dot_sum      = '0;
    elem_pos     = 0;
    word_ptr     = 0;
    slot_pos     = 0;
    bits_cfg     = 4'd4;
    elems_cfg    = '0;
    words_cfg    = '0;
    bias_cfg     = '0;
    bias_en_cfg  = 1'b0;
    accum_en_cfg = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_field_extremes();
    test_width_change();
    test_word_limit();
    test_random_traffic(0, 0);
    test_random_traffic(56, 0);
    test_random_traffic(0, 56);
    test_random_traffic(24, 24);

    drain();
    if (expected_rows.size() != 0)
      flag_error($sformatf("%0d row results never arrived", expected_rows.size()));

    $display("Run covered %0d requests and %0d row results over %0d register writes,",
             requests_sent, rows_checked, reg_writes);
    $display("with steady, sender-idle, receiver-stall and mixed pacing.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
